>>> sv/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg: shared types and constants of the directed cycle finder
// Sizes of the node and edge tables and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package dcf_pkg;
  localparam int MaxNodes = 32;
  localparam int MaxEdges = 256;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EdgeW = $clog2(MaxEdges);
  localparam int CntW = EdgeW + 1;
  localparam int DepthW = NodeW + 1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ROOT,
    ST_STEP,
    ST_EDGE,
    ST_EMIT,
    ST_NONE,
    ST_CLEAR
  } state_t;
endpackage
`default_nettype wire

>>> sv/directed_cycle_finder_top.sv
// ----------------------------------------------------------------------------
// directed_cycle_finder_top: streaming edge loader and DFS cycle search
// Loads edges, then walks the graph depth first and reports one cycle, if any.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests are taken when start is high and busy is low. Each
//   request carries an optional edge (in_edge_source -> in_edge_target,
//   valid when in_has_edge). An edge is stored as it is accepted, so plain
//   edge requests may follow back to back.
//   A request with in_last_item set ends the graph: busy rises and the
//   search runs over one shared sequencer that reads one edge per step
//   through the registered edge memories (each edge visited passes
//   through ST_STEP and ST_EDGE).
//   Results leave on out_* ports, one per cycle, each marked by
//   out_valid; the receiver cannot stall. A found cycle gives its path
//   nodes, then the closing node with out_last_result set. An acyclic
//   graph gives one result with out_cycle_found clear.
//   After the results a clearing pass over all MaxNodes entries resets the
//   per-node valid and visit flags; the edge memories are never cleared,
//   since list heads and per-edge link valid bits decide what is read.
//   Reset empties all lists and counters.
// ----------------------------------------------------------------------------
`default_nettype none
module directed_cycle_finder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [4:0] in_edge_source,
  input  wire logic [5:0] in_edge_target,
  input  wire logic       in_has_edge,
  input  wire logic [5:0] in_node_count,
  input  wire logic       in_last_item,
  output logic            out_valid,
  output logic [4:0]      out_cycle_node,
  output logic            out_cycle_found,
  output logic            out_edge_overflow,
  output logic            out_last_result
);
  localparam int NW = dcf_pkg::NodeW;
  localparam int EW = dcf_pkg::EdgeW;
  localparam int CW = dcf_pkg::CntW;
  localparam int DW = dcf_pkg::DepthW;
  localparam int NN = dcf_pkg::MaxNodes;

  dcf_pkg::state_t state_r, state_nxt;

  // per-node tables (small, flops)
  logic [NN-1:0]   head_v_r;
  logic [EW-1:0]   head_r [NN];
  logic [EW-1:0]   tail_r [NN];
  logic [NN-1:0]   onpath_r, done_r;
  logic [DW-1:0]   pos_r [NN];
  logic [NW-1:0]   stk_node_r [NN];
  logic [EW-1:0]   stk_cur_r [NN];
  logic [NN-1:0]   stk_cv_r;
  logic [NN-1:0]   link_v_r [dcf_pkg::MaxEdges / NN];

  logic [CW-1:0]   loaded_r;
  logic            ovf_r;
  logic [DW-1:0]   depth_r;
  logic [DW-1:0]   n_r;
  logic [DW-1:0]   root_r;
  logic [DW-1:0]   emit_r;
  logic [NW-1:0]   tgt_r;
  logic [NW-1:0]   clr_r;

  // edge memories
  logic            mem_we;
  logic [EW-1:0]   lnk_waddr, rd_addr;
  logic [5:0]      dest_rd;
  logic [EW-1:0]   link_rd;
  logic            link_v_rd_r;

  wire accept = start && !busy;
  wire in_store = accept && in_has_edge && !loaded_r[CW-1];
  wire [NW-1:0] src = in_edge_source[NW-1:0];
  wire [DW-1:0] top = depth_r - DW'(1);
  wire [NW-1:0] topi = top[NW-1:0];
  wire [NW-1:0] top_node = stk_node_r[topi];
  wire [EW-1:0] new_e = loaded_r[EW-1:0];
  wire [DW-1:0] n_in = (in_node_count > 6'(NN)) ? DW'(NN) : DW'(in_node_count);
  wire [NW-1:0] ri = root_r[NW-1:0];
  wire          tgt_ok = {2'b00, dest_rd} < {2'b00, n_r};
  wire [NW-1:0] tn = dest_rd[NW-1:0];
  wire [EW-1:0] link_idx = stk_cur_r[topi];

  assign mem_we    = in_store;
  assign lnk_waddr = tail_r[src];
  assign rd_addr   = link_idx;

  dcf_ram #(.Depth(dcf_pkg::MaxEdges), .Width(6)) u_dest (
    .clk(clk), .we(mem_we), .waddr(new_e), .wdata(in_edge_target),
    .raddr(rd_addr), .rdata(dest_rd)
  );
  dcf_ram #(.Depth(dcf_pkg::MaxEdges), .Width(EW)) u_link (
    .clk(clk), .we(mem_we && head_v_r[src]), .waddr(lnk_waddr), .wdata(new_e),
    .raddr(rd_addr), .rdata(link_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dcf_pkg::ST_LOAD:
        if (accept && in_last_item) begin
          state_nxt = (n_in == '0) ? dcf_pkg::ST_NONE : dcf_pkg::ST_ROOT;
        end
      dcf_pkg::ST_ROOT:
        if (root_r >= n_r) begin
          state_nxt = dcf_pkg::ST_NONE;
        end else if (!onpath_r[ri] && !done_r[ri]) begin
          state_nxt = dcf_pkg::ST_STEP;
        end
      dcf_pkg::ST_STEP:
        if (depth_r == '0) begin
          state_nxt = dcf_pkg::ST_ROOT;
        end else if (stk_cv_r[topi]) begin
          state_nxt = dcf_pkg::ST_EDGE;
        end
      dcf_pkg::ST_EDGE:
        if (tgt_ok && onpath_r[tn]) begin
          state_nxt = dcf_pkg::ST_EMIT;
        end else begin
          state_nxt = dcf_pkg::ST_STEP;
        end
      dcf_pkg::ST_EMIT:
        if (emit_r == depth_r) begin
          state_nxt = dcf_pkg::ST_CLEAR;
        end
      dcf_pkg::ST_NONE:  state_nxt = dcf_pkg::ST_CLEAR;
      dcf_pkg::ST_CLEAR:
        if (clr_r == NW'(NN - 1)) begin
          state_nxt = dcf_pkg::ST_LOAD;
        end
      default: state_nxt = dcf_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    busy              = (state_r != dcf_pkg::ST_LOAD);
    out_valid         = 1'b0;
    out_cycle_node    = '0;
    out_cycle_found   = 1'b0;
    out_edge_overflow = ovf_r;
    out_last_result   = 1'b0;
    case (state_r)
      dcf_pkg::ST_EMIT: begin
        out_valid       = 1'b1;
        out_cycle_found = 1'b1;
        if (emit_r == depth_r) begin
          out_cycle_node  = 5'(tgt_r);
          out_last_result = 1'b1;
        end else begin
          out_cycle_node = 5'(stk_node_r[emit_r[NW-1:0]]);
        end
      end
      dcf_pkg::ST_NONE: begin
        out_valid       = 1'b1;
        out_last_result = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    link_v_rd_r <= link_v_r[link_idx[EW-1:NW]][link_idx[NW-1:0]];
    if (in_store) begin
      tail_r[src] <= new_e;
      link_v_r[new_e[EW-1:NW]][new_e[NW-1:0]] <= 1'b0;
      if (!head_v_r[src]) begin
        head_r[src] <= new_e;
      end else begin
        link_v_r[lnk_waddr[EW-1:NW]][lnk_waddr[NW-1:0]] <= 1'b1;
      end
    end
    if (state_r == dcf_pkg::ST_ROOT && root_r < n_r && !onpath_r[ri] && !done_r[ri]) begin
      pos_r[ri]         <= '0;
      stk_node_r[0]     <= ri;
      stk_cur_r[0]      <= head_r[ri];
    end
    if (state_r == dcf_pkg::ST_EDGE) begin
      tgt_r <= tn;
      stk_cur_r[topi] <= link_rd;
      if (tgt_ok && !onpath_r[tn] && !done_r[tn]) begin
        pos_r[tn]                  <= depth_r;
        stk_node_r[depth_r[NW-1:0]] <= tn;
        stk_cur_r[depth_r[NW-1:0]]  <= head_r[tn];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dcf_pkg::ST_LOAD;
      head_v_r <= '0;
      onpath_r <= '0;
      done_r   <= '0;
      stk_cv_r <= '0;
      loaded_r <= '0;
      ovf_r    <= 1'b0;
      depth_r  <= '0;
      n_r      <= '0;
      root_r   <= '0;
      emit_r   <= '0;
      clr_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        dcf_pkg::ST_LOAD: begin
          if (accept && in_has_edge) begin
            if (loaded_r[CW-1]) begin
              ovf_r <= 1'b1;
            end else begin
              loaded_r      <= loaded_r + CW'(1);
              head_v_r[src] <= 1'b1;
            end
          end
          if (accept && in_last_item) begin
            n_r    <= n_in;
            root_r <= '0;
          end
        end
        dcf_pkg::ST_ROOT: begin
          if (root_r < n_r) begin
            root_r <= root_r + DW'(1);
            if (!onpath_r[ri] && !done_r[ri]) begin
              onpath_r[ri] <= 1'b1;
              stk_cv_r[0]  <= head_v_r[ri];
              depth_r      <= DW'(1);
            end
          end
        end
        dcf_pkg::ST_STEP: begin
          if (depth_r != '0 && !stk_cv_r[topi]) begin
            onpath_r[top_node] <= 1'b0;
            done_r[top_node]   <= 1'b1;
            depth_r            <= top;
          end
        end
        dcf_pkg::ST_EDGE: begin
          stk_cv_r[topi] <= link_v_rd_r;
          if (tgt_ok && onpath_r[tn]) begin
            emit_r <= pos_r[tn];
          end else if (tgt_ok && !done_r[tn] && depth_r < DW'(NN)) begin
            onpath_r[tn]               <= 1'b1;
            stk_cv_r[depth_r[NW-1:0]]  <= head_v_r[tn];
            depth_r                    <= depth_r + DW'(1);
          end
        end
        dcf_pkg::ST_EMIT: begin
          if (emit_r != depth_r) begin
            emit_r <= emit_r + DW'(1);
          end else begin
            clr_r <= '0;
          end
        end
        dcf_pkg::ST_NONE: clr_r <= '0;
        dcf_pkg::ST_CLEAR: begin
          head_v_r[clr_r] <= 1'b0;
          onpath_r[clr_r] <= 1'b0;
          done_r[clr_r]   <= 1'b0;
          clr_r           <= clr_r + NW'(1);
          loaded_r        <= '0;
          ovf_r           <= (clr_r == NW'(NN - 1)) ? 1'b0 : ovf_r;
          depth_r         <= '0;
        end
        default: ;
      endcase
    end
  end

  // a result only leaves while busy
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside search");
  // last result is followed by the clearing pass
  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> state_r == dcf_pkg::ST_CLEAR)
    else $error("no clear after last result");
  // a node is never both on the path and finished
  a_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (onpath_r & done_r) == '0) else $error("visit marks overlap");
  // edge count never exceeds the store
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CW'(dcf_pkg::MaxEdges)) else $error("edge count overflow");
endmodule
`default_nettype wire

>>> sv/dcf_ram.sv
// ----------------------------------------------------------------------------
// dcf_ram: single write, single registered read port memory
// Generic storage used for the edge target and link tables.
// ----------------------------------------------------------------------------
`default_nettype none
module dcf_ram #(
  parameter int Depth = 256,
  parameter int Width = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for directed_cycle_finder_top
// Streams edge lists, predicts the DFS cycle report of each graph and checks
// every result field against a queue of expected reports.
// ----------------------------------------------------------------------------
module tb;

  // One expected result of the cycle report.
  typedef struct packed {
    logic [4:0] node;
    logic       found;
    logic       ovf;
    logic       last;
  } report_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [4:0] in_edge_source;
  logic [5:0] in_edge_target;
  logic       in_has_edge;
  logic [5:0] in_node_count;
  logic       in_last_item;
  logic       out_valid;
  logic [4:0] out_cycle_node;
  logic       out_cycle_found;
  logic       out_edge_overflow;
  logic       out_last_result;

  directed_cycle_finder_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_edge_source   (in_edge_source),
    .in_edge_target   (in_edge_target),
    .in_has_edge      (in_has_edge),
    .in_node_count    (in_node_count),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_cycle_node   (out_cycle_node),
    .out_cycle_found  (out_cycle_found),
    .out_edge_overflow(out_edge_overflow),
    .out_last_result  (out_last_result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Graph as the predictor holds it: a plain edge list in arrival order.
  // Walking it in order per source gives the same successor order as the
  // linked lists inside the block.
  logic [4:0] graph_src [$];
  logic [5:0] graph_dst [$];
  logic       graph_ovf;

  report_t    cycle_reports [$];
  int         mismatch_count;
  int         report_count;
  int         graph_count;
  int         cyclic_count;
  int         send_idle_pct;

  // Drop rules of the edge store: sources past the table vanish silently,
  // edges past a full store vanish and flag overflow.
  task automatic note_edge(input logic [4:0] s, input logic [5:0] d);
    if (s >= dcf_pkg::MaxNodes) return;
    if (graph_src.size() >= dcf_pkg::MaxEdges) begin
      graph_ovf = 1'b1;
      return;
    end
    graph_src = {graph_src, s};
    graph_dst = {graph_dst, d};
  endtask

  // Iterative DFS with per-level cursors into the edge list; queues the
  // expected cycle report and then forgets the graph.
  task automatic predict_cycle(input logic [5:0] count_in);
    int n;
    int mark [dcf_pkg::MaxNodes];
    int pos [dcf_pkg::MaxNodes];
    int stk [dcf_pkg::MaxNodes];
    int cur [dcf_pkg::MaxNodes];
    int depth;
    int top;
    int e;
    int t;
    bit done;
    report_t r;
    n = (count_in > dcf_pkg::MaxNodes) ? dcf_pkg::MaxNodes : int'(count_in);
    done = 0;
    foreach (mark[i]) mark[i] = 0;
    for (int root = 0; root < n && !done; root++) begin
      if (mark[root] != 0) continue;
      depth = 1;
      stk[0] = root;
      cur[0] = 0;
      mark[root] = 1;
      pos[root] = 0;
      while (depth > 0 && !done) begin
        top = depth - 1;
        e = cur[top];
        while (e < graph_src.size() && graph_src[e] != stk[top]) e++;
        if (e >= graph_src.size()) begin
          mark[stk[top]] = 2;
          depth = top;
          continue;
        end
        cur[top] = e + 1;
        t = graph_dst[e];
        if (t >= n) continue;
        if (mark[t] == 0) begin
          mark[t] = 1;
          pos[t] = depth;
          stk[depth] = t;
          cur[depth] = 0;
          depth++;
        end else if (mark[t] == 1) begin
          for (int p = pos[t]; p <= top; p++) begin
            r = '{node: stk[p][4:0], found: 1'b1, ovf: graph_ovf, last: 1'b0};
            cycle_reports = {cycle_reports, r};
          end
          r = '{node: t[4:0], found: 1'b1, ovf: graph_ovf, last: 1'b1};
          cycle_reports = {cycle_reports, r};
          done = 1;
          cyclic_count++;
        end
      end
    end
    if (!done) begin
      r = '{node: 5'd0, found: 1'b0, ovf: graph_ovf, last: 1'b1};
      cycle_reports = {cycle_reports, r};
    end
    graph_src.delete();
    graph_dst.delete();
    graph_ovf = 1'b0;
    graph_count++;
  endtask

  // Sends one request and feeds it to the predictor once accepted. start
  // stays high between back-to-back requests and drops only while idling
  // or after the request that closes a graph.
  task automatic send_request(input logic [4:0] s, input logic [5:0] d,
                              input logic has, input logic [5:0] n,
                              input logic last);
    if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk);
      while ($urandom_range(99, 0) < send_idle_pct);
    end
    start          <= 1'b1;
    in_edge_source <= s;
    in_edge_target <= d;
    in_has_edge    <= has;
    in_node_count  <= n;
    in_last_item   <= last;
    // busy only moves at rising edges, so look at it mid-cycle
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    // accepted at this edge
    if (has) note_edge(s, d);
    if (last) begin
      predict_cycle(n);
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_edge(input int s, input int d);
    send_request(s[4:0], d[5:0], 1'b1, 6'($urandom_range(63, 0)), 1'b0);
  endtask

  task automatic close_graph(input int n);
    send_request(5'($urandom_range(31, 0)), 6'($urandom_range(63, 0)), 1'b0,
                 n[5:0], 1'b1);
  endtask

  task automatic wait_drained();
    while (cycle_reports.size() != 0) @(posedge clk);
  endtask

  // Result checker: the block cannot be stalled, so every strobe is a report.
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid) begin
      report_count++;
      if (cycle_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result node=%0d found=%0b", $realtime,
                   out_cycle_node, out_cycle_found);
      end else begin
        want = cycle_reports.pop_front();
        if (out_cycle_node !== want.node || out_cycle_found !== want.found ||
            out_edge_overflow !== want.ovf || out_last_result !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp n=%0d f=%0b o=%0b l=%0b got n=%0d f=%0b o=%0b l=%0b",
                     $realtime, want.node, want.found, want.ovf, want.last,
                     out_cycle_node, out_cycle_found, out_edge_overflow,
                     out_last_result);
        end
      end
    end
  end

  // Directed: self loop, simple ring, acyclic chain, zero nodes, saturated
  // node count, out-of-range target, source past node count, empty last item.
  task automatic test_directed();
    send_edge(0, 0);
    close_graph(1);
    send_edge(0, 1); send_edge(1, 2); send_edge(2, 0);
    send_request(5'd2, 6'd3, 1'b1, 6'd3, 1'b1); // last item carries an edge
    send_edge(0, 1); send_edge(1, 2);
    close_graph(3);
    send_edge(0, 0);
    close_graph(0);
    send_edge(31, 30); send_edge(30, 31);
    close_graph(63);
    send_edge(0, 63); send_edge(0, 5); send_edge(5, 0);
    close_graph(5);  // target 5 is out of range
    send_edge(3, 4); send_edge(4, 3);
    close_graph(2);  // cyclic nodes never visited
    close_graph(32);
    send_edge(1, 0); send_edge(0, 1);
    close_graph(32);
  endtask

  // Overfills the edge store with a chain; its closing edge is dropped.
  task automatic test_overflow();
    for (int i = 0; i < dcf_pkg::MaxEdges + 1; i++) send_edge(i % 31, i % 31 + 1);
    send_edge(31, 0); // dropped: store full
    close_graph(32);
  endtask

  // Random graphs with small node counts so cycles and acyclic cases mix.
  task automatic test_random(input int items);
    int sent;
    int n;
    int k;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(8, 1);
      if ($urandom_range(9, 0) == 0) n = $urandom_range(63, 0);
      k = $urandom_range(6, 0);
      for (int j = 0; j < k; j++) begin
        if ($urandom_range(9, 0) == 0)
          send_request(5'($urandom_range(31, 0)), 6'($urandom_range(63, 0)),
                       1'($urandom_range(1, 0)), 6'($urandom_range(63, 0)), 1'b0);
        else
          send_edge($urandom_range(n > 0 ? (n > 32 ? 31 : n - 1) : 0, 0),
                    $urandom_range(n > 0 ? n : 0, 0));
      end
      send_request(5'($urandom_range(31, 0)), 6'($urandom_range(63, 0)),
                   1'($urandom_range(1, 0)), n[5:0], 1'b1);
      sent += k + 1;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_edge_source = '0;
    in_edge_target = '0;
    in_has_edge = 1'b0;
    in_node_count = '0;
    in_last_item = 1'b0;
    graph_ovf = 1'b0;
    mismatch_count = 0;
    report_count = 0;
    graph_count = 0;
    cyclic_count = 0;
    send_idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(8);
    wait_drained();       // sender holds off until every report is back
    send_idle_pct = 81;
    test_random(8);
    send_idle_pct = 9;
    test_random(8);
    send_idle_pct = 0;
    test_random(8);
    wait_drained();
    repeat (100) @(posedge clk);
    $display("Covered directed corner graphs, a full edge store and random graphs");
    $display("under sender gaps: %0d graphs (%0d cyclic), %0d results, %0d mismatches",
             graph_count, cyclic_count, report_count, mismatch_count);
    if (mismatch_count == 0 && cycle_reports.size() == 0)
      $display("directed_cycle_finder_top verification clean");
    else
      $display("directed_cycle_finder_top verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("directed_cycle_finder_top verification failed");
    $finish;
  end
endmodule
